// ===== hdl/dssa_pkg.sv =====
package dssa_pkg;

	localparam int HOURS = 24;
	localparam int HOUR_IDX_W = (HOURS > 1) ? $clog2(HOURS) : 1;
	localparam logic [5:0] HOUR_LIM = 6'(HOURS);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [7:0]  TEMP_MIN_RST = 8'h7f;
	localparam logic [7:0]  TEMP_MAX_RST = 8'h80;
	localparam logic [15:0] COUNT_MAX    = 16'hffff;

	typedef struct packed {
		logic        start;
		logic [15:0] mean;
		logic [15:0] count;
		logic [15:0] sample;
		logic [15:0] divisor;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quot;
	} md_rsp_t;

endpackage

// ===== hdl/dssa_muldiv.sv =====
module dssa_muldiv
	import dssa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam logic [1:0] MD_IDLE = 2'd0;
	localparam logic [1:0] MD_MUL  = 2'd1;
	localparam logic [1:0] MD_ADD  = 2'd2;
	localparam logic [1:0] MD_DIV  = 2'd3;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [15:0] a_q;
	logic [15:0] b_q;
	logic [15:0] c_q;
	logic [15:0] d_q;
	logic [31:0] acc_q;
	logic [15:0] rem_q;
	logic [16:0] sh_q;

	logic [31:0] sum;
	logic [16:0] trial;
	logic        ge;

	assign sum   = acc_q + {16'd0, c_q};
	assign trial = {rem_q, sh_q[16]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_MUL;
						cnt_q   <= '0;
					end
				end
				MD_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= MD_ADD;
					end
				end
				MD_ADD: begin
					state_q <= MD_DIV;
					cnt_q   <= '0;
				end
				MD_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// shift-add multiply, add of the sample, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q   <= req.mean;
					b_q   <= req.count;
					c_q   <= req.sample;
					d_q   <= req.divisor;
					acc_q <= '0;
				end
			end
			MD_MUL: begin
				acc_q <= {acc_q[30:0], 1'b0} + (b_q[15] ? {16'd0, a_q} : 32'd0);
				b_q   <= {b_q[14:0], 1'b0};
			end
			MD_ADD: begin
				rem_q <= {1'b0, sum[31:17]};
				sh_q  <= sum[16:0];
			end
			MD_DIV: begin
				rem_q <= ge ? 16'(trial - {1'b0, d_q}) : trial[15:0];
				sh_q  <= {sh_q[15:0], ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

// ===== hdl/daily_sensor_stats_accumulator.sv =====
// channel   dir  tdata                                          tuser
// s_*       in   temperature, humidity, pressure, weather_code,  command
//                hour_of_day
// m_*       out  day stats, hourly entry                         -
//
// add runs a 16-step shift-add multiply, one add and a 17-step divide in the mean
// units, humidity and pressure in parallel
// clear, read and the unused code go from idle straight to the push state, which loads the result
// one item at a time; the next beat is taken once the result sits in the output register
// arst_n clears the day statistics and the hourly valid bits
// a stalled output holds the block after the next item is done
module daily_sensor_stats_accumulator
	import dssa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // temperature, humidity, pressure, weather_code, hour_of_day
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // day_temp_min, day_temp_max, day_humidity_avg,
	                              // day_pressure_avg, day_weather, day_samples, hour_temp,
	                              // hour_humidity, hour_weather
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;

	logic signed [15:0] in_temp;
	logic [7:0]         in_hum;
	logic [15:0]        in_pres;
	logic [9:0]         in_wid;
	logic [4:0]         in_hour;
	logic               in_beat;
	logic               in_hour_ok;

	assign in_temp    = $signed(s_tdata[15:0]);
	assign in_hum     = s_tdata[23:16];
	assign in_pres    = s_tdata[39:24];
	assign in_wid     = s_tdata[49:40];
	assign in_hour    = s_tdata[54:50];
	assign in_beat    = s_tvalid && s_tready;
	assign in_hour_ok = {1'b0, in_hour} < HOUR_LIM;

	// sixteenths to half degrees, toward zero, saturated
	logic signed [16:0] temp_bias;
	logic signed [16:0] temp_div;
	logic signed [7:0]  temp_half;

	assign temp_bias = 17'(in_temp) + ((in_temp < 0) ? 17'sd7 : 17'sd0);
	assign temp_div  = temp_bias >>> 3;
	always_comb begin
		if (temp_div > 17'sd127) begin
			temp_half = 8'sd127;
		end else if (temp_div < -17'sd128) begin
			temp_half = -8'sd128;
		end else begin
			temp_half = temp_div[7:0];
		end
	end

	logic [1:0]         cmd_q;
	logic signed [7:0]  temp_q;
	logic [7:0]         hum_q;
	logic [9:0]         wid_q;
	logic [4:0]         hour_q;
	logic               hour_ok_q;

	logic signed [7:0]  min_q;
	logic signed [7:0]  max_q;
	logic [7:0]         hmean_q;
	logic [15:0]        pmean_q;
	logic [9:0]         weather_q;
	logic [15:0]        count_q;

	logic [23:0]        hour_mem [HOURS];
	logic [HOURS-1:0]   hour_vld_q;
	logic [23:0]        rd_q;
	logic               rd_ok_q;

	logic [15:0]        count_next;
	assign count_next = (count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;

	md_req_t hreq;
	md_req_t preq;
	md_rsp_t hrsp;
	md_rsp_t prsp;

	assign hreq.start   = in_beat && (s_tuser == CMD_ADD);
	assign hreq.mean    = {8'd0, hmean_q};
	assign hreq.count   = count_q;
	assign hreq.sample  = {8'd0, in_hum};
	assign hreq.divisor = count_next;

	assign preq.start   = hreq.start;
	assign preq.mean    = pmean_q;
	assign preq.count   = count_q;
	assign preq.sample  = in_pres;
	assign preq.divisor = count_next;

	dssa_muldiv u_hum_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	dssa_muldiv u_pres_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.rsp    (prsp)
	);

	logic [HOUR_IDX_W-1:0] in_idx;
	logic [HOUR_IDX_W-1:0] wr_idx;
	assign in_idx = in_hour[HOUR_IDX_W-1:0];
	assign wr_idx = hour_q[HOUR_IDX_W-1:0];

	logic out_load;
	assign out_load = (state_q == ST_PUSH) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			min_q      <= $signed(TEMP_MIN_RST);
			max_q      <= $signed(TEMP_MAX_RST);
			hmean_q    <= '0;
			pmean_q    <= '0;
			weather_q  <= '0;
			count_q    <= '0;
			hour_vld_q <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (s_tuser == CMD_ADD) begin
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_PUSH;
						end
						if (s_tuser == CMD_CLEAR) begin
							min_q     <= $signed(TEMP_MIN_RST);
							max_q     <= $signed(TEMP_MAX_RST);
							hmean_q   <= '0;
							pmean_q   <= '0;
							weather_q <= '0;
							count_q   <= '0;
						end
					end
				end
				ST_CALC: begin
					if (hrsp.done) begin
						state_q   <= ST_PUSH;
						min_q     <= (temp_q < min_q) ? temp_q : min_q;
						max_q     <= (temp_q > max_q) ? temp_q : max_q;
						hmean_q   <= (hrsp.quot > 17'd255) ? 8'hff : hrsp.quot[7:0];
						pmean_q   <= prsp.quot[16] ? 16'hffff : prsp.quot[15:0];
						weather_q <= wid_q;
						count_q   <= count_next;
						if (hour_ok_q) begin
							hour_vld_q[wr_idx] <= 1'b1;
						end
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q     <= s_tuser;
			temp_q    <= temp_half;
			hum_q     <= in_hum;
			wid_q     <= in_wid;
			hour_q    <= in_hour;
			hour_ok_q <= in_hour_ok;
			rd_ok_q   <= in_hour_ok && hour_vld_q[in_idx];
			if (in_hour_ok) begin
				rd_q <= hour_mem[in_idx];
			end
		end
		if ((state_q == ST_CALC) && hrsp.done && hour_ok_q) begin
			hour_mem[wr_idx] <= {wid_q[7:0], hum_q, temp_q};
		end
	end

	logic [23:0] hour_out;
	assign hour_out = ((cmd_q == CMD_READ) && rd_ok_q) ? rd_q : 24'd0;

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {6'd0, hour_out, count_q, weather_q, pmean_q, hmean_q, max_q, min_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ===== hdl/dssa_checker.sv =====
module dssa_checker
	import dssa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// one item in flight
	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("beat taken while an item is in flight");

	// empty day shows reset extremes and zero mean
	ap_empty_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[65:50] == 16'd0) |->
		(m_tdata[7:0] == TEMP_MIN_RST) && (m_tdata[15:8] == TEMP_MAX_RST) &&
		(m_tdata[23:16] == 8'd0) && (m_tdata[39:24] == 16'd0))
		else $error("empty day stats wrong");

	// once samples exist min is not above max
	ap_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[65:50] != 16'd0) |->
		$signed(m_tdata[7:0]) <= $signed(m_tdata[15:8]))
		else $error("day min above day max");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

endmodule

bind daily_sensor_stats_accumulator dssa_checker u_dssa_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import dssa_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HALF_DEG_MAX = 127;
	localparam int HALF_DEG_MIN = -128;
	localparam int SAMPLES_MAX = 65535;
	localparam int HUM_MEAN_MAX = 255;
	localparam int PRES_MEAN_MAX = 65535;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic        pad;
		logic [4:0]  hour_of_day;
		logic [9:0]  weather_code;
		logic [15:0] pressure;
		logic [7:0]  humidity;
		logic [15:0] temperature;
	} sample_beat_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic [7:0]  hour_weather;
		logic [7:0]  hour_humidity;
		logic [7:0]  hour_temp;
		logic [15:0] day_samples;
		logic [9:0]  day_weather;
		logic [15:0] day_pressure_avg;
		logic [7:0]  day_humidity_avg;
		logic [7:0]  day_temp_max;
		logic [7:0]  day_temp_min;
	} day_report_t;

	class day_stats_board;
		int lo_temp;
		int hi_temp;
		int hum_mean;
		int pres_mean;
		int last_wx;
		int n_samples;
		logic [7:0] slot_temp [HOURS];
		logic [7:0] slot_hum [HOURS];
		logic [7:0] slot_wx [HOURS];
		day_report_t expected_reports[$];
		int errors;

		function new();
			clear_day();
			foreach (slot_temp[i]) begin
				slot_temp[i] = '0;
				slot_hum[i] = '0;
				slot_wx[i] = '0;
			end
			errors = 0;
		endfunction

		function void clear_day();
			lo_temp = HALF_DEG_MAX;
			hi_temp = HALF_DEG_MIN;
			hum_mean = 0;
			pres_mean = 0;
			last_wx = 0;
			n_samples = 0;
		endfunction

		function void predict_report(logic [1:0] cmd, sample_beat_t b);
			int t;
			longint hsum, psum, hq, pq;
			day_report_t r;
			r = '0;
			case (cmd)
				CMD_ADD: begin
					t = $signed(b.temperature);
					t = t / 8;
					if (t > HALF_DEG_MAX) t = HALF_DEG_MAX;
					if (t < HALF_DEG_MIN) t = HALF_DEG_MIN;
					if (t < lo_temp) lo_temp = t;
					if (t > hi_temp) hi_temp = t;
					hsum = longint'(hum_mean) * n_samples + b.humidity;
					psum = longint'(pres_mean) * n_samples + b.pressure;
					if (n_samples < SAMPLES_MAX) n_samples++;
					hq = hsum / n_samples;
					pq = psum / n_samples;
					hum_mean = (hq > HUM_MEAN_MAX) ? HUM_MEAN_MAX : int'(hq);
					pres_mean = (pq > PRES_MEAN_MAX) ? PRES_MEAN_MAX : int'(pq);
					last_wx = b.weather_code;
					if (b.hour_of_day < HOURS) begin
						slot_temp[b.hour_of_day] = 8'(t);
						slot_hum[b.hour_of_day] = b.humidity;
						slot_wx[b.hour_of_day] = b.weather_code[7:0];
					end
				end
				CMD_CLEAR: begin
					clear_day();
				end
				CMD_READ: begin
					if (b.hour_of_day < HOURS) begin
						r.hour_temp = slot_temp[b.hour_of_day];
						r.hour_humidity = slot_hum[b.hour_of_day];
						r.hour_weather = slot_wx[b.hour_of_day];
					end
				end
				default: begin
				end
			endcase
			r.day_temp_min = 8'(lo_temp);
			r.day_temp_max = 8'(hi_temp);
			r.day_humidity_avg = 8'(hum_mean);
			r.day_pressure_avg = 16'(pres_mean);
			r.day_weather = 10'(last_wx);
			r.day_samples = 16'(n_samples);
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_report(day_report_t got);
			day_report_t want;
			if (expected_reports.size() == 0) begin
				$error("result beat with no expected report: %h", got);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				compare_field("day_temp_min", $signed(want.day_temp_min),
					$signed(got.day_temp_min));
				compare_field("day_temp_max", $signed(want.day_temp_max),
					$signed(got.day_temp_max));
				compare_field("day_humidity_avg", want.day_humidity_avg, got.day_humidity_avg);
				compare_field("day_pressure_avg", want.day_pressure_avg, got.day_pressure_avg);
				compare_field("day_weather", want.day_weather, got.day_weather);
				compare_field("day_samples", want.day_samples, got.day_samples);
				compare_field("hour_temp", $signed(want.hour_temp), $signed(got.hour_temp));
				compare_field("hour_humidity", want.hour_humidity, got.hour_humidity);
				compare_field("hour_weather", want.hour_weather, got.hour_weather);
				compare_field("pad", want.pad, got.pad);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	day_stats_board board;
	int tx_idle_pct;
	int rx_idle_pct;
	int beats_in;
	int quiet_cycles;

	daily_sensor_stats_accumulator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			board.predict_report(s_tuser, s_tdata);
			beats_in++;
		end
		if (m_tvalid && m_tready)
			board.check_report(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL daily_sensor_stats_accumulator");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(logic [1:0] cmd, logic [15:0] temp, logic [7:0] hum,
		logic [15:0] pres, logic [9:0] wx, logic [4:0] hour);
		sample_beat_t b;
		int n0;
		b.pad = 1'b0;
		b.hour_of_day = hour;
		b.weather_code = wx;
		b.pressure = pres;
		b.humidity = hum;
		b.temperature = temp;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		n0 = beats_in;
		do
			@(negedge clk);
		while (beats_in == n0);
	endtask

	task automatic send_random(int count);
		logic [1:0] cmd;
		logic [15:0] temp;
		logic [4:0] hour;
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 84) cmd = CMD_ADD;
			else if (r < 93) cmd = CMD_READ;
			else if (r < 96) cmd = CMD_CLEAR;
			else cmd = CMD_UNUSED;
			if ($urandom_range(1))
				temp = 16'($urandom);
			else
				temp = 16'($urandom_range(2200) - 1100);
			if ($urandom_range(3) == 0)
				hour = 5'($urandom_range(31));
			else
				hour = 5'($urandom_range(HOURS - 1));
			send_beat(cmd, temp, 8'($urandom), 16'($urandom), 10'($urandom_range(1023)),
				hour);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		beats_in = 0;
		quiet_cycles = 0;
		tx_idle_pct = 30;
		rx_idle_pct = 78;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty day and unused code
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd0);
		send_beat(CMD_UNUSED, 16'hffff, 8'hff, 16'hffff, 10'h3ff, 5'd31);
		// field extremes, saturation of the half-degree value
		send_beat(CMD_ADD, 16'h7fff, 8'd255, 16'hffff, 10'd1023, 5'd0);
		send_beat(CMD_ADD, 16'h8000, 8'd0, 16'd0, 10'd0, 5'd23);
		// truncation toward zero
		send_beat(CMD_ADD, -16'sd15, 8'd40, 16'd1013, 10'd300, 5'd5);
		send_beat(CMD_ADD, -16'sd7, 8'd41, 16'd1000, 10'd301, 5'd6);
		send_beat(CMD_ADD, 16'sd7, 8'd42, 16'd999, 10'd302, 5'd7);
		// hour beyond the table
		send_beat(CMD_ADD, -16'sd8, 8'd43, 16'd998, 10'd511, 5'd24);
		send_beat(CMD_ADD, 16'sd1016, 8'd44, 16'd997, 10'd512, 5'd31);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd0);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd23);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd5);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd24);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd31);
		// clear keeps the hourly table
		send_beat(CMD_CLEAR, 16'd0, 8'd0, 16'd0, 10'd0, 5'd0);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd0);
		send_beat(CMD_UNUSED, 16'd0, 8'd0, 16'd0, 10'd0, 5'd7);
		send_beat(CMD_ADD, -16'sd1024, 8'd100, 16'd1020, 10'd7, 5'd1);
		send_beat(CMD_ADD, -16'sd1031, 8'd99, 16'd1021, 10'd8, 5'd2);
		send_beat(CMD_ADD, 16'sd1023, 8'd98, 16'd1022, 10'd9, 5'd3);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd2);
		send_beat(CMD_READ, 16'd0, 8'd0, 16'd0, 10'd0, 5'd3);

		send_random(RANDOM_PER_PHASE);
		tx_idle_pct = 78;
		rx_idle_pct = 30;
		send_random(RANDOM_PER_PHASE);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(RANDOM_PER_PHASE);
		s_tvalid <= 1'b0;

		while (board.expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0)
			$display("PASS daily_sensor_stats_accumulator");
		else
			$display("FAIL daily_sensor_stats_accumulator");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dssa_pkg.sv
hdl/dssa_muldiv.sv
hdl/daily_sensor_stats_accumulator.sv
hdl/dssa_checker.sv
verif/tb.sv
